[hw/rtl/bresenham_line_rasterizer_top_macros.svh]
// assertion macros for the bresenham line rasterizer
// no dependencies; the assertions themselves are left out when SYNTH is defined
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

`ifndef SYNTH

// checked only while out of reset
`define BLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BLR_ASSERT(lbl, prop, msg)
`define BLR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/blr_pkg.sv]
// shared constants, operation codes and the coordinate clamp helper for the line rasterizer
// no dependencies
package blr_pkg;

  localparam int unsigned SCREEN_WIDTH  = 1024;
  localparam int unsigned SCREEN_HEIGHT = 768;

  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned ADDR_W     = 20;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // saturate a signed input coordinate to 0..lim_max
  function automatic logic signed [COORD_IN_W:0] clamp_coord(
    input logic signed [COORD_IN_W-1:0] v,
    input logic signed [COORD_IN_W:0]   lim_max
  );
    logic signed [COORD_IN_W:0] ext;
    ext = {v[COORD_IN_W-1], v};
    if (ext < 0) begin
      return '0;
    end else if (ext > lim_max) begin
      return lim_max;
    end
    return ext;
  endfunction

endpackage

[hw/rtl/bresenham_line_rasterizer_top.sv]
// bresenham line rasterizer, top level and only module
// depends on blr_pkg and bresenham_line_rasterizer_top_macros.svh

// Takes one word per clock while results are taken, and returns one word for each.
// A begin word (tuser 0) clamps both endpoints onto the screen, sets up the
// deltas, step signs and major axis, and returns the start pixel. A step
// word (tuser 1) moves one pixel along the line and returns it; the final
// pixel has tlast set. A step with no line in progress returns a word with
// tuser 0 and all data zero. The step is one add, one compare and one
// subtract on the error term plus the address multiply by the constant
// screen width, all between the line state registers and the output
// register, so a word is accepted every clock as long as the output side
// keeps taking results; the single output register lets a new word in
// while the previous result is being taken.
module bresenham_line_rasterizer_top #(
  parameter int unsigned SCREEN_WIDTH  = blr_pkg::SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = blr_pkg::SCREEN_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48], line_color[95:64]
  input  logic [95:0] s_axis_tdata,
  // operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_address[19:0], pixel_color[51:20], zero fill[55:52]
  output logic [55:0] m_axis_tdata,
  // pixel_valid[0]
  output logic        m_axis_tuser,
  // last_pixel
  output logic        m_axis_tlast
);

  localparam int unsigned CI_W   = blr_pkg::COORD_IN_W;
  localparam int unsigned COL_W  = blr_pkg::COLOR_W;
  localparam int unsigned ADR_W  = blr_pkg::ADDR_W;
  localparam int unsigned MAXDIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int unsigned CW     = $clog2(MAXDIM);
  localparam int unsigned EW     = CW + 1;
  localparam int unsigned PW     = (2 * CW + 1 > ADR_W) ? 2 * CW + 1 : ADR_W;
  localparam int unsigned OUT_W  = ADR_W + COL_W;

  localparam logic signed [CI_W:0] X_MAX = (CI_W + 1)'(SCREEN_WIDTH - 1);
  localparam logic signed [CI_W:0] Y_MAX = (CI_W + 1)'(SCREEN_HEIGHT - 1);
  localparam logic [PW-1:0]        W_MUL = PW'(SCREEN_WIDTH);

  // line state
  logic [CW-1:0]    cur_x_q, cur_x_d;
  logic [CW-1:0]    cur_y_q, cur_y_d;
  logic [EW-1:0]    err_acc_q, err_acc_d;
  logic [CW-1:0]    major_delta_q, major_delta_d;
  logic [CW-1:0]    minor_delta_q, minor_delta_d;
  logic             x_step_neg_q, x_step_neg_d;
  logic             y_step_neg_q, y_step_neg_d;
  logic             x_is_major_q, x_is_major_d;
  logic [CW-1:0]    steps_left_q, steps_left_d;
  logic [COL_W-1:0] held_color_q, held_color_d;
  logic             line_active_q, line_active_d;

  // output register
  logic             out_valid_q;
  logic             out_pix_q, out_pix_d;
  logic             out_last_q, out_last_d;
  logic [ADR_W-1:0] out_addr_q, out_addr_d;
  logic [COL_W-1:0] out_color_q, out_color_d;

  logic             in_acc;
  blr_pkg::op_e     op;
  logic [CW-1:0]    x0, y0, x1, y1;
  logic [CW-1:0]    dx, dy;
  logic [EW-1:0]    err_sum;
  logic             minor_move;
  logic [PW-1:0]    addr_full;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op            = blr_pkg::op_e'(s_axis_tuser);

  assign x0 = CW'(blr_pkg::clamp_coord(s_axis_tdata[CI_W-1:0], X_MAX));
  assign y0 = CW'(blr_pkg::clamp_coord(s_axis_tdata[2*CI_W-1:CI_W], Y_MAX));
  assign x1 = CW'(blr_pkg::clamp_coord(s_axis_tdata[3*CI_W-1:2*CI_W], X_MAX));
  assign y1 = CW'(blr_pkg::clamp_coord(s_axis_tdata[4*CI_W-1:3*CI_W], Y_MAX));

  assign dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
  assign dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);

  // error never exceeds twice the major delta, so one extra bit is enough
  assign err_sum    = err_acc_q + EW'(minor_delta_q);
  assign minor_move = err_sum >= EW'(major_delta_q);

  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    err_acc_d     = err_acc_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    x_step_neg_d  = x_step_neg_q;
    y_step_neg_d  = y_step_neg_q;
    x_is_major_d  = x_is_major_q;
    steps_left_d  = steps_left_q;
    held_color_d  = held_color_q;
    line_active_d = line_active_q;
    out_pix_d     = 1'b0;
    out_last_d    = 1'b0;
    out_color_d   = '0;

    case (op)
      blr_pkg::OP_BEGIN: begin
        cur_x_d       = x0;
        cur_y_d       = y0;
        x_step_neg_d  = !(x1 > x0);
        y_step_neg_d  = !(y1 > y0);
        x_is_major_d  = dx > dy;
        major_delta_d = (dx > dy) ? dx : dy;
        minor_delta_d = (dx > dy) ? dy : dx;
        err_acc_d     = EW'(major_delta_d >> 1);
        steps_left_d  = major_delta_d;
        held_color_d  = s_axis_tdata[4*CI_W +: COL_W];
        line_active_d = major_delta_d != '0;
        out_pix_d     = 1'b1;
        out_last_d    = major_delta_d == '0;
        out_color_d   = held_color_d;
      end
      blr_pkg::OP_STEP: begin
        if (line_active_q) begin
          err_acc_d = minor_move ? (err_sum - EW'(major_delta_q)) : err_sum;
          if (x_is_major_q || minor_move) begin
            cur_x_d = x_step_neg_q ? (cur_x_q - CW'(1)) : (cur_x_q + CW'(1));
          end
          if (!x_is_major_q || minor_move) begin
            cur_y_d = y_step_neg_q ? (cur_y_q - CW'(1)) : (cur_y_q + CW'(1));
          end
          steps_left_d  = steps_left_q - CW'(1);
          line_active_d = steps_left_d != '0;
          out_pix_d     = 1'b1;
          out_last_d    = steps_left_d == '0;
          out_color_d   = held_color_q;
        end
      end
      default: begin
        out_pix_d = 1'b0;
      end
    endcase
  end

  assign addr_full  = PW'(cur_y_d) * W_MUL + PW'(cur_x_d);
  assign out_addr_d = out_pix_d ? addr_full[ADR_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      err_acc_q     <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      x_step_neg_q  <= 1'b0;
      y_step_neg_q  <= 1'b0;
      x_is_major_q  <= 1'b0;
      steps_left_q  <= '0;
      held_color_q  <= '0;
      line_active_q <= 1'b0;
    end else if (in_acc) begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      err_acc_q     <= err_acc_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      x_step_neg_q  <= x_step_neg_d;
      y_step_neg_q  <= y_step_neg_d;
      x_is_major_q  <= x_is_major_d;
      steps_left_q  <= steps_left_d;
      held_color_q  <= held_color_d;
      line_active_q <= line_active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, only looked at while out_valid_q is set
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_pix_q   <= out_pix_d;
      out_last_q  <= out_last_d;
      out_addr_q  <= out_addr_d;
      out_color_q <= out_color_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_pix_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(56 - OUT_W){1'b0}}, out_color_q, out_addr_q};

`include "bresenham_line_rasterizer_top_macros.svh"

  `BLR_ASSERT(a_active_has_steps, line_active_q |-> (steps_left_q != '0),
    "active line with no steps")
  `BLR_ASSERT(a_last_is_pixel, (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser,
    "last flag on empty word")
  `BLR_ASSERT(a_idle_step_empty,
    (in_acc && op == blr_pkg::OP_STEP && !line_active_q) |=> !m_axis_tuser,
    "idle step emitted a pixel")
  `BLR_ASSERT(a_step_counts_down,
    (in_acc && op == blr_pkg::OP_STEP && line_active_q) |=>
      (steps_left_q == $past(steps_left_q) - CW'(1)),
    "step count did not drop")
  `BLR_ASSERT_ALWAYS(a_x_on_screen, cur_x_q <= CW'(SCREEN_WIDTH - 1), "x left the screen")

endmodule
